FILE: design/x86rf_pkg.sv
// Shared types and constants for the x86-64 register file and address unit.
// No dependencies; the interfaces refer to this package and the core imports it.
package x86rf_pkg;

	localparam int unsigned GP_REGS_DEFAULT = 16;
	localparam int unsigned NUM_FLAGS       = 6;
	localparam int unsigned NUM_VEC_REGS    = 16;
	localparam int unsigned QUADS           = 4;
	localparam int unsigned QUAD_W          = 64;
	localparam int unsigned REG_NUM_W       = 4;

	// operation codes
	localparam logic [2:0] FUNC_READ  = 3'd0;
	localparam logic [2:0] FUNC_WRITE = 3'd1;
	localparam logic [2:0] FUNC_ADDR  = 3'd2;
	localparam logic [2:0] FUNC_FLAG  = 3'd3;
	localparam logic [2:0] FUNC_SZP   = 3'd4;

	// operand kinds
	localparam logic [2:0] KIND_GP64  = 3'd0;
	localparam logic [2:0] KIND_GP32  = 3'd1;
	localparam logic [2:0] KIND_GP16  = 3'd2;
	localparam logic [2:0] KIND_GP8L  = 3'd3;
	localparam logic [2:0] KIND_GP8H  = 3'd4;
	localparam logic [2:0] KIND_XMM   = 3'd5;
	localparam logic [2:0] KIND_YMM   = 3'd6;

	// flag bit positions
	localparam int unsigned FLAG_CF = 0;
	localparam int unsigned FLAG_PF = 1;
	localparam int unsigned FLAG_AF = 2;
	localparam int unsigned FLAG_ZF = 3;
	localparam int unsigned FLAG_SF = 4;
	localparam int unsigned FLAG_OF = 5;

	// addr_mode bits
	localparam int unsigned AM_BASE  = 0;
	localparam int unsigned AM_INDEX = 1;
	localparam int unsigned AM_RIP   = 2;
	localparam int unsigned AM_TRUNC = 3;

	typedef struct packed {
		logic [2:0]        func;
		logic [2:0]        kind;
		logic [3:0]        reg_a;
		logic [3:0]        reg_b;
		logic [3:0]        addr_mode;
		logic [1:0]        scale_log2;
		logic              write_option;
		logic [QUAD_W-1:0] data_q0;
		logic [QUAD_W-1:0] data_q1;
		logic [QUAD_W-1:0] data_q2;
		logic [QUAD_W-1:0] data_q3;
	} req_t;

	typedef struct packed {
		logic [QUAD_W-1:0]    result_q0;
		logic [QUAD_W-1:0]    result_q1;
		logic [QUAD_W-1:0]    result_q2;
		logic [QUAD_W-1:0]    result_q3;
		logic [NUM_FLAGS-1:0] flags_now;
	} rsp_t;

endpackage

FILE: design/x86rf_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on x86rf_pkg for the payload types.
interface x86rf_req_if;
	logic              valid;
	logic              ready;
	x86rf_pkg::req_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface x86rf_rsp_if;
	logic              valid;
	logic              ready;
	x86rf_pkg::rsp_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/x86_register_file_and_agu_core.sv
// x86-64 architectural register file with partial-register writes, flags
// and effective-address generation. Depends on x86rf_pkg and x86rf_if.sv.
//
// Usage:
//   in_ch  : one request per handshake (valid & ready): read/write operand,
//            compute address, write one flag, or set SF/ZF/PF.
//   out_ch : exactly one response per request, in request order. It holds
//            the read value or address and the flags after the request.
//   cfg_wr_en/cfg_wr_data : load the RIP used for rip-relative addresses.
//            Write only while no request is in flight.
// Timing:
//   An accepted request is registered with the register file read data (two
//   GP read ports, one 256-bit vector row read). Its response is loaded into
//   the output register when that is empty or out_ch.ready is high. State
//   updates land on the same edge, and a request accepted on it has its reads
//   forwarded, so back-to-back requests see each other's writes. One request
//   per cycle sustained while out_ch.ready is high; the 64-bit
//   base+index+displacement add in the request stage sets the cycle time.
// Stall: when out_ch.ready is low the output register holds, the request
//   stage holds behind it and in_ch.ready drops once that stage is full.
// Reset: all GP, vector and flag state reads as zero (per-entry valid bits,
//   no clearing pass), RIP is zero, both stages are empty.
module x86_register_file_and_agu_core #(
	parameter int unsigned NUM_GP_REGS = x86rf_pkg::GP_REGS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [x86rf_pkg::QUAD_W-1:0] cfg_wr_data,
	x86rf_req_if.sink                   in_ch,
	x86rf_rsp_if.source                 out_ch
);
	import x86rf_pkg::*;

	localparam int GP_IDX_W  = (NUM_GP_REGS > 1) ? $clog2(NUM_GP_REGS) : 1;
	// one spare bit so NUM_GP_REGS itself fits for the range compare
	localparam int REG_EXT_W = ((GP_IDX_W > REG_NUM_W) ? GP_IDX_W : REG_NUM_W) + 1;
	localparam int VEC_IDX_W = $clog2(NUM_VEC_REGS);

	// ---------------- handshake ----------------
	logic valid_s1;
	logic out_valid_q;
	logic s1_adv;
	logic in_acc;

	assign s1_adv       = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || s1_adv;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;

	// ---------------- storage ----------------
	logic [QUAD_W-1:0]                  gp_mem [NUM_GP_REGS];
	logic [NUM_GP_REGS-1:0]             gp_vld_q;
	logic [QUAD_W-1:0]                  vq_mem [QUADS][NUM_VEC_REGS];
	logic [NUM_VEC_REGS-1:0][QUADS-1:0] vq_vld_q;
	logic [NUM_FLAGS-1:0]               flags_q;
	logic [QUAD_W-1:0]                  ip_q;

	// ---------------- read address decode at accept ----------------
	logic [3:0]           gpa_num;
	logic [REG_EXT_W-1:0] gpa_ext, gpb_ext;
	logic                 gpa_ok, gpb_ok;
	logic [GP_IDX_W-1:0]  gpa_idx, gpb_idx;
	logic [VEC_IDX_W-1:0] vec_rd_row;

	// high-byte operands address AH..BH through registers 0..3
	assign gpa_num = ((in_ch.payload.func == FUNC_READ || in_ch.payload.func == FUNC_WRITE) &&
			in_ch.payload.kind == KIND_GP8H) ? {2'b00, in_ch.payload.reg_a[1:0]}
			: in_ch.payload.reg_a;
	assign gpa_ext = REG_EXT_W'(gpa_num);
	assign gpb_ext = REG_EXT_W'(in_ch.payload.reg_b);
	assign gpa_ok  = gpa_ext < REG_EXT_W'(NUM_GP_REGS);
	assign gpb_ok  = gpb_ext < REG_EXT_W'(NUM_GP_REGS);
	assign gpa_idx = gpa_ok ? gpa_ext[GP_IDX_W-1:0] : '0;
	assign gpb_idx = gpb_ok ? gpb_ext[GP_IDX_W-1:0] : '0;
	assign vec_rd_row = in_ch.payload.reg_a[VEC_IDX_W-1:0];

	// ---------------- request stage registers ----------------
	req_t                          req_s1;
	logic [GP_IDX_W-1:0]           gpa_idx_s1;
	logic                          gpa_ok_s1;
	logic [QUAD_W-1:0]             gpa_rd_s1, gpb_rd_s1, gp_fwd_s1;
	logic                          gpa_hit_s1, gpa_live_s1, gpb_hit_s1, gpb_live_s1;
	logic [QUADS-1:0][QUAD_W-1:0]  vq_rd_s1, vq_fwd_s1;
	logic [QUADS-1:0]              vq_hit_s1, vq_live_s1;

	// ---------------- write port (driven from the request stage) ----------------
	logic                          gp_we, gp_we_raw;
	logic [QUAD_W-1:0]             gp_wr_data;
	logic [QUADS-1:0]              vq_we, vq_we_raw;
	logic [QUADS-1:0][QUAD_W-1:0]  vq_wr_data;
	logic [VEC_IDX_W-1:0]          vec_wr_row;

	assign gp_we      = s1_adv && gp_we_raw && gpa_ok_s1;
	assign vq_we      = {QUADS{s1_adv}} & vq_we_raw;
	assign vec_wr_row = req_s1.reg_a[VEC_IDX_W-1:0];

	// memories: write from the request stage, registered read at accept
	always_ff @(posedge clk) begin
		if (gp_we) begin
			gp_mem[gpa_idx_s1] <= gp_wr_data;
		end
		if (in_acc) begin
			gpa_rd_s1 <= gp_mem[gpa_idx];
			gpb_rd_s1 <= gp_mem[gpb_idx];
		end
	end

	always_ff @(posedge clk) begin
		for (int q = 0; q < QUADS; q++) begin
			if (vq_we[q]) begin
				vq_mem[q][vec_wr_row] <= vq_wr_data[q];
			end
			if (in_acc) begin
				vq_rd_s1[q] <= vq_mem[q][vec_rd_row];
			end
		end
	end

	// request payload plus forwarding selects for a write landing on the same edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1      <= in_ch.payload;
			gpa_idx_s1  <= gpa_idx;
			gpa_ok_s1   <= gpa_ok;
			gp_fwd_s1   <= gp_wr_data;
			gpa_hit_s1  <= gp_we && gpa_ok && (gpa_idx_s1 == gpa_idx);
			gpb_hit_s1  <= gp_we && gpb_ok && (gpa_idx_s1 == gpb_idx);
			gpa_live_s1 <= gpa_ok && gp_vld_q[gpa_idx];
			gpb_live_s1 <= gpb_ok && gp_vld_q[gpb_idx];
			vq_fwd_s1   <= vq_wr_data;
			for (int q = 0; q < QUADS; q++) begin
				vq_hit_s1[q]  <= vq_we[q] && (vec_wr_row == vec_rd_row);
				vq_live_s1[q] <= vq_vld_q[vec_rd_row][q];
			end
		end
	end

	// ---------------- operand values ----------------
	logic [QUAD_W-1:0]            gpa_val, gpb_val;
	logic [QUADS-1:0][QUAD_W-1:0] vq_val;

	assign gpa_val = gpa_hit_s1 ? gp_fwd_s1 : (gpa_live_s1 ? gpa_rd_s1 : '0);
	assign gpb_val = gpb_hit_s1 ? gp_fwd_s1 : (gpb_live_s1 ? gpb_rd_s1 : '0);

	always_comb begin
		for (int q = 0; q < QUADS; q++) begin
			vq_val[q] = vq_hit_s1[q] ? vq_fwd_s1[q] : (vq_live_s1[q] ? vq_rd_s1[q] : '0);
		end
	end

	// ---------------- address generation ----------------
	logic [QUAD_W-1:0] disp_ext, base_term, index_term, agu_sum, agu_addr;

	assign disp_ext   = {{32{req_s1.data_q0[31]}}, req_s1.data_q0[31:0]};
	assign base_term  = req_s1.addr_mode[AM_BASE] ? gpa_val : '0;
	assign index_term = req_s1.addr_mode[AM_INDEX] ? (gpb_val << req_s1.scale_log2) : '0;
	assign agu_sum    = req_s1.addr_mode[AM_RIP] ? (disp_ext + ip_q)
			: (disp_ext + base_term + index_term);
	assign agu_addr   = req_s1.addr_mode[AM_TRUNC] ? {32'd0, agu_sum[31:0]} : agu_sum;

	// ---------------- SF/ZF/PF from the request data ----------------
	logic szp_ok, szp_sf, szp_zf, szp_pf;

	assign szp_pf = ~^req_s1.data_q0[7:0];

	always_comb begin
		szp_ok = 1'b1;
		szp_sf = 1'b0;
		szp_zf = 1'b0;
		case (req_s1.kind)
			KIND_GP64: begin
				szp_sf = req_s1.data_q0[63];
				szp_zf = req_s1.data_q0 == '0;
			end
			KIND_GP32: begin
				szp_sf = req_s1.data_q0[31];
				szp_zf = req_s1.data_q0[31:0] == '0;
			end
			KIND_GP16: begin
				szp_sf = req_s1.data_q0[15];
				szp_zf = req_s1.data_q0[15:0] == '0;
			end
			KIND_GP8L, KIND_GP8H: begin
				szp_sf = req_s1.data_q0[7];
				szp_zf = req_s1.data_q0[7:0] == '0;
			end
			KIND_XMM: begin
				szp_sf = req_s1.data_q1[63];
				szp_zf = (req_s1.data_q0 | req_s1.data_q1) == '0;
			end
			KIND_YMM: begin
				szp_sf = req_s1.data_q3[63];
				szp_zf = (req_s1.data_q0 | req_s1.data_q1 | req_s1.data_q2 |
						req_s1.data_q3) == '0;
			end
			default: begin
				szp_ok = 1'b0;
			end
		endcase
	end

	// ---------------- operation decode ----------------
	rsp_t                 rsp;
	logic [NUM_FLAGS-1:0] flags_nxt;
	logic [QUAD_W-1:0]    d0;

	assign d0 = req_s1.data_q0;

	always_comb begin
		rsp        = '0;
		flags_nxt  = flags_q;
		gp_we_raw  = 1'b0;
		gp_wr_data = d0;
		vq_we_raw  = '0;
		vq_wr_data = '0;
		case (req_s1.func)
			FUNC_READ: begin
				case (req_s1.kind)
					KIND_GP64: rsp.result_q0 = gpa_val;
					KIND_GP32: rsp.result_q0 = {32'd0, gpa_val[31:0]};
					KIND_GP16: rsp.result_q0 = {48'd0, gpa_val[15:0]};
					KIND_GP8L: rsp.result_q0 = {56'd0, gpa_val[7:0]};
					KIND_GP8H: rsp.result_q0 = {56'd0, gpa_val[15:8]};
					KIND_XMM: begin
						rsp.result_q0 = vq_val[0];
						rsp.result_q1 = vq_val[1];
					end
					KIND_YMM: begin
						rsp.result_q0 = vq_val[0];
						rsp.result_q1 = vq_val[1];
						rsp.result_q2 = vq_val[2];
						rsp.result_q3 = vq_val[3];
					end
					default: ;
				endcase
			end
			FUNC_WRITE: begin
				case (req_s1.kind)
					KIND_GP64: begin
						gp_we_raw  = 1'b1;
						gp_wr_data = d0;
					end
					KIND_GP32: begin
						gp_we_raw  = 1'b1;
						// keep form preserves the upper half, else it is zeroed
						gp_wr_data = req_s1.write_option ? {gpa_val[63:32], d0[31:0]}
								: {32'd0, d0[31:0]};
					end
					KIND_GP16: begin
						gp_we_raw  = 1'b1;
						gp_wr_data = {gpa_val[63:16], d0[15:0]};
					end
					KIND_GP8L: begin
						gp_we_raw  = 1'b1;
						gp_wr_data = {gpa_val[63:8], d0[7:0]};
					end
					KIND_GP8H: begin
						gp_we_raw  = 1'b1;
						gp_wr_data = {gpa_val[63:16], d0[7:0], gpa_val[7:0]};
					end
					KIND_XMM: begin
						// AVX form clears the upper lane, legacy form leaves it
						vq_we_raw     = {req_s1.write_option, req_s1.write_option, 2'b11};
						vq_wr_data[0] = d0;
						vq_wr_data[1] = req_s1.data_q1;
					end
					KIND_YMM: begin
						vq_we_raw     = '1;
						vq_wr_data[0] = d0;
						vq_wr_data[1] = req_s1.data_q1;
						vq_wr_data[2] = req_s1.data_q2;
						vq_wr_data[3] = req_s1.data_q3;
					end
					default: ;
				endcase
			end
			FUNC_ADDR: begin
				rsp.result_q0 = agu_addr;
			end
			FUNC_FLAG: begin
				if (req_s1.reg_b < 4'(NUM_FLAGS)) begin
					flags_nxt[req_s1.reg_b[2:0]] = d0[0];
				end
			end
			FUNC_SZP: begin
				if (szp_ok) begin
					flags_nxt[FLAG_SF] = szp_sf;
					flags_nxt[FLAG_ZF] = szp_zf;
					flags_nxt[FLAG_PF] = szp_pf;
				end
			end
			default: ;
		endcase
		rsp.flags_now = flags_nxt;
	end

	// ---------------- control state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
			ip_q        <= '0;
			gp_vld_q    <= '0;
			vq_vld_q    <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				flags_q     <= flags_nxt;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				ip_q <= cfg_wr_data;
			end
			if (gp_we) begin
				gp_vld_q[gpa_idx_s1] <= 1'b1;
			end
			for (int q = 0; q < QUADS; q++) begin
				if (vq_we[q]) begin
					vq_vld_q[vec_wr_row][q] <= 1'b1;
				end
			end
		end
	end

	// output register payload
	rsp_t out_q;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= rsp;
		end
	end

	assign out_ch.payload = out_q;

endmodule
